// ===== rtl/pli_pkg.sv =====
// Shared constants, codes and controller/datapath types of the interpolator.
package pli_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_VALUE_BITS  = 32;

  localparam int OP_BITS          = 1;
  localparam int ENTRY_INDEX_BITS = 6;
  localparam int ENERGY_BITS      = 32;
  localparam int SECTION_BITS     = 32;
  localparam int RESULT_BITS      = 32;
  localparam int CFG_BITS         = 7;

  localparam logic [CFG_BITS-1:0] ENTRIES_RESET = 7'd2;

  localparam logic [OP_BITS-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_BITS-1:0] OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic q_start;
    logic cap_prev;
    logic cap_seg;
    logic mul;
    logic div_step;
    logic fin;
    logic res_oor;
    logic res_none;
    logic load_out;
  } pli_cmd_t;

  // Comparison results from the datapath to the controller.
  typedef struct packed {
    logic oor;
    logic hit;
    logic zero_w;
  } pli_status_t;

endpackage

// ===== rtl/pli_in_if.sv =====
// Input item channel: valid, ready and one load or query item.
interface pli_in_if import pli_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          operation;
  logic [ENTRY_INDEX_BITS-1:0] entry_index;
  logic [ENERGY_BITS-1:0]      energy;
  logic [SECTION_BITS-1:0]     section_value;

  modport source (output valid, output operation, output entry_index, output energy,
                  output section_value, input ready);
  modport sink (input valid, input operation, input entry_index, input energy,
                input section_value, output ready);
endinterface

// ===== rtl/pli_out_if.sv =====
// Result channel: valid, ready and one interpolated result.
interface pli_out_if import pli_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] interpolated_value;
  logic                   out_of_range;

  modport source (output valid, output interpolated_value, output out_of_range,
                  input ready);
  modport sink (input valid, input interpolated_value, input out_of_range,
                output ready);
endinterface

// ===== rtl/pli_cfg_if.sv =====
// Configuration write channel carrying the entry count register.
interface pli_cfg_if import pli_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] entries_in_use;

  modport source (output valid, output entries_in_use, input ready);
  modport sink (input valid, input entries_in_use, output ready);
endinterface

// ===== rtl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator over a breakpoint table.
//
//  Channel   Direction  Payload                                         Transfer
//  in_chan   sink       operation, entry_index, energy, section_value   valid & ready
//  out_chan  source     interpolated_value, out_of_range                valid & ready
//  cfg_chan  sink       entries_in_use                                  valid & ready
//
// A load writes both breakpoint memories in the transfer cycle if entry_index < TABLE_DEPTH.
// A query reads the first and last breakpoints for a range check, scans the segments
// one memory read a cycle, then multiplies and runs the bit-serial divider steps;
// an out-of-range query ends after the range check and a zero-width segment after the scan.
// Reset clears control state only; the table is undefined until loaded.
// The result register lets a new item transfer while a result waits on a stalled out_chan.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int VALUE_BITS  = DEFAULT_VALUE_BITS
) (
  input logic         clk,
  input logic         rst_n,
  pli_in_if.sink      in_chan,
  pli_out_if.source   out_chan,
  pli_cfg_if.sink     cfg_chan
);

  localparam int AW = $clog2(TABLE_DEPTH);

  pli_cmd_t      cmd;
  pli_status_t   status;
  logic [AW-1:0] rd_addr;

  pli_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.operation),
    .in_ready  (in_chan.ready),
    .cfg_valid (cfg_chan.valid),
    .cfg_data  (cfg_chan.entries_in_use),
    .cfg_ready (cfg_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  pli_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk              (clk),
    .in_entry_index   (in_chan.entry_index),
    .in_energy        (in_chan.energy),
    .in_section_value (in_chan.section_value),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .status           (status),
    .out_value        (out_chan.interpolated_value),
    .out_oor          (out_chan.out_of_range)
  );

  // A load never raises a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.operation == OP_LOAD && !out_chan.valid)
    |=> !out_chan.valid)
    else $error("load transfer produced a result");

  // A query occupies the block for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.operation == OP_QUERY)
    |=> !in_chan.ready)
    else $error("input accepted directly after a query");

  // Out-of-range results always carry a zero value.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_of_range) |-> (out_chan.interpolated_value == '0))
    else $error("out-of-range result with non-zero value");

endmodule

// ===== rtl/pli_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pli_ram import pli_pkg::*; #(
  parameter int WIDTH = ENERGY_BITS,
  parameter int DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/pli_ctrl.sv =====
// Controller: sequences load, range check, segment scan, multiply and divide.
module pli_ctrl import pli_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int VALUE_BITS  = DEFAULT_VALUE_BITS,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OP_BITS-1:0]  in_op,
  output logic                in_ready,
  input  logic                cfg_valid,
  input  logic [CFG_BITS-1:0] cfg_data,
  output logic                cfg_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pli_status_t         status,
  output pli_cmd_t            cmd,
  output logic [AW-1:0]       rd_addr
);

  localparam int SW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CNTW = $clog2(SW);
  localparam int NW   = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = (NW > CFG_BITS) ? NW : CFG_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AW-1:0]       seg_r, seg_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [CFG_BITS-1:0] cfg_r;
  logic [CW-1:0]       cfg_ext, n_act, seg_next2;

  // Entry counts outside the table's limits act as the nearest limit.
  assign cfg_ext   = CW'(cfg_r);
  assign n_act     = (cfg_ext < CW'(2)) ? CW'(2) :
                     ((cfg_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cfg_ext);
  assign seg_next2 = CW'(seg_r) + CW'(2);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    seg_nxt       = seg_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    rd_addr       = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.q_start = 1'b1;
            state_nxt   = S_FIRST;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_FIRST: begin
        cmd.cap_prev = 1'b1;
        rd_addr      = AW'(n_act - CW'(1));
        state_nxt    = S_LAST;
      end
      S_LAST: begin
        if (status.oor) begin
          cmd.res_oor = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          rd_addr   = AW'(1);
          seg_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.cap_seg = 1'b1;
          state_nxt   = status.zero_w ? S_DONE : S_MUL;
        end else if (seg_next2 == n_act) begin
          // Energies that do not rise can leave the query in no segment.
          cmd.res_none = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.cap_prev = 1'b1;
          rd_addr      = AW'(seg_next2);
          seg_nxt      = seg_r + AW'(1);
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNTW'(SW - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seg_r       <= '0;
      cnt_r       <= '0;
      cfg_r       <= ENTRIES_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seg_r       <= seg_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/pli_dp.sv =====
// Datapath: breakpoint memories, comparators, multiplier and restoring divider.
module pli_dp import pli_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int VALUE_BITS  = DEFAULT_VALUE_BITS,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic [ENTRY_INDEX_BITS-1:0] in_entry_index,
  input  logic [ENERGY_BITS-1:0]      in_energy,
  input  logic [SECTION_BITS-1:0]     in_section_value,
  input  pli_cmd_t                    cmd,
  input  logic [AW-1:0]               rd_addr,
  output pli_status_t                 status,
  output logic [RESULT_BITS-1:0]      out_value,
  output logic                        out_oor
);

  localparam int SW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int PW   = SW + ENERGY_BITS;
  localparam int NW   = $clog2(TABLE_DEPTH + 1);
  localparam int IXW  = (NW > ENTRY_INDEX_BITS) ? NW : ENTRY_INDEX_BITS;
  localparam logic [SECTION_BITS-1:0] VMAX = SECTION_BITS'((64'd1 << SW) - 64'd1);

  logic                   idx_ok, wr_en;
  logic [SW-1:0]          wr_val;
  logic [ENERGY_BITS-1:0] rd_e;
  logic [SW-1:0]          rd_v;

  logic [ENERGY_BITS-1:0] qe_r, prev_e_r, span_r, offs_r, rem_r;
  logic [SW-1:0]          prev_v_r, mag_r, v0_r, low_r, res_val_r;
  logic                   up_r, res_oor_r;
  logic [RESULT_BITS-1:0] out_value_r;
  logic                   out_oor_r;

  logic [PW-1:0]          prod;
  logic [ENERGY_BITS:0]   trial, diff;
  logic                   q_bit;
  logic [SW-1:0]          fin_val;

  assign idx_ok = (IXW'(in_entry_index) < IXW'(TABLE_DEPTH));
  assign wr_en  = cmd.load_wr && idx_ok;
  assign wr_val = (in_section_value > VMAX) ? VMAX[SW-1:0] : in_section_value[SW-1:0];

  pli_ram #(.WIDTH(ENERGY_BITS), .DEPTH(TABLE_DEPTH)) u_energy_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_energy),
    .rd_addr (rd_addr),
    .rd_data (rd_e)
  );

  pli_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (wr_val),
    .rd_addr (rd_addr),
    .rd_data (rd_v)
  );

  // prev holds the lower end of the segment, the read data its upper end.
  assign status.oor    = (qe_r < prev_e_r) || (qe_r > rd_e);
  assign status.hit    = (prev_e_r <= qe_r) && (qe_r <= rd_e);
  assign status.zero_w = (prev_e_r == rd_e);

  assign prod = PW'(mag_r) * PW'(offs_r);

  // The quotient never exceeds the value step, so the upper product bits
  // already lie below the span and only SW quotient bits remain.
  assign trial = {rem_r, low_r[SW-1]};
  assign diff  = trial - {1'b0, span_r};
  assign q_bit = (trial >= {1'b0, span_r});

  assign fin_val = up_r ? (v0_r + low_r) : ((low_r >= v0_r) ? '0 : (v0_r - low_r));

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qe_r <= in_energy;
    end
    if (cmd.cap_prev) begin
      prev_e_r <= rd_e;
      prev_v_r <= rd_v;
    end
    if (cmd.cap_seg) begin
      span_r    <= rd_e - prev_e_r;
      offs_r    <= qe_r - prev_e_r;
      up_r      <= (rd_v >= prev_v_r);
      mag_r     <= (rd_v >= prev_v_r) ? (rd_v - prev_v_r) : (prev_v_r - rd_v);
      v0_r      <= prev_v_r;
      res_val_r <= prev_v_r;
      res_oor_r <= 1'b0;
    end
    if (cmd.mul) begin
      rem_r <= prod[PW-1:SW];
      low_r <= prod[SW-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? diff[ENERGY_BITS-1:0] : trial[ENERGY_BITS-1:0];
      low_r <= {low_r[SW-2:0], q_bit};
    end
    if (cmd.fin) begin
      res_val_r <= fin_val;
    end
    if (cmd.res_oor) begin
      res_val_r <= '0;
      res_oor_r <= 1'b1;
    end
    if (cmd.res_none) begin
      res_val_r <= '0;
      res_oor_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_value_r <= RESULT_BITS'(res_val_r);
      out_oor_r   <= res_oor_r;
    end
  end

  assign out_value = out_value_r;
  assign out_oor   = out_oor_r;

endmodule
